/* rtl/core/u8d_pkg.sv */
// Shared types, constants and decode functions for the UTF-8 decoder.
package u8d_pkg;

  localparam int BYTE_W     = 8;
  localparam int CP_W       = 21;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int WIN_DEPTH  = 4;
  localparam int CNT_W      = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  // Register map: the register index is bit 2 of the byte address.
  localparam logic CFG_REPL_IDX = 1'b0;
  localparam logic [CP_W-1:0] REPL_RESET = 21'h00003F;

  // Range limits of the decoded scalar values.
  localparam logic [CP_W-1:0] MIN_CP2 = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CP3 = 21'h000800;
  localparam logic [CP_W-1:0] SURR_LO = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI = 21'h00DFFF;
  localparam logic [CP_W-1:0] MIN_CP4 = 21'h010000;
  localparam logic [CP_W-1:0] MAX_CP  = 21'h10FFFF;

  // Sequence lengths announced by a lead byte.
  localparam logic [CNT_W-1:0] LEN_NONE = 3'd0;
  localparam logic [CNT_W-1:0] LEN_1    = 3'd1;
  localparam logic [CNT_W-1:0] LEN_2    = 3'd2;
  localparam logic [CNT_W-1:0] LEN_3    = 3'd3;
  localparam logic [CNT_W-1:0] LEN_4    = 3'd4;

  // Window of held bytes, entry 0 is the oldest.
  typedef logic [WIN_DEPTH-1:0][BYTE_W-1:0] win_t;

  // One queued request after the front has classified it.
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              has_byte;
    logic              fin;
  } q_entry_t;

  // Outcome of examining the window at its oldest byte.
  typedef struct packed {
    logic              stop;
    logic              replaced;
    logic [CP_W-1:0]   cp;
    logic [CNT_W-1:0]  consume;
  } step_t;

  function automatic logic [CNT_W-1:0] lead_length(logic [BYTE_W-1:0] b);
    logic [CNT_W-1:0] len;
    if (b[7] == 1'b0) begin
      len = LEN_1;
    end else if (b[7:5] == 3'b110) begin
      len = LEN_2;
    end else if (b[7:4] == 4'b1110) begin
      len = LEN_3;
    end else if (b[7:3] == 5'b11110) begin
      len = LEN_4;
    end else begin
      len = LEN_NONE;
    end
    return len;
  endfunction

  function automatic logic is_cont(logic [BYTE_W-1:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // Decide what the oldest byte of the window gives, if anything yet.
  function automatic step_t classify(win_t w, logic [CNT_W-1:0] n, logic fin);
    step_t            s;
    logic [CNT_W-1:0] len;
    logic             bad;
    logic [CP_W-1:0]  cp;
    logic             ok;
    s   = '0;
    len = lead_length(w[0]);
    bad = (len >= LEN_2 && n >= 3'd2 && !is_cont(w[1])) ||
          (len >= LEN_3 && n >= 3'd3 && !is_cont(w[2])) ||
          (len >= LEN_4 && n >= 3'd4 && !is_cont(w[3]));
    cp  = '0;
    ok  = 1'b0;
    if (n == 3'd0) begin
      s.stop = 1'b1;
    end else if (len == LEN_NONE) begin
      s.replaced = 1'b1;
      s.consume  = 3'd1;
    end else if (len == LEN_1) begin
      s.cp      = {13'd0, w[0]};
      s.consume = 3'd1;
    end else if (!bad && n < len && !fin) begin
      // Incomplete but still plausible: wait for more bytes.
      s.stop = 1'b1;
    end else if (bad || n < len) begin
      s.replaced = 1'b1;
      s.consume  = 3'd1;
    end else begin
      if (len == LEN_2) begin
        cp = {10'd0, w[0][4:0], w[1][5:0]};
        ok = cp >= MIN_CP2;
      end else if (len == LEN_3) begin
        cp = {5'd0, w[0][3:0], w[1][5:0], w[2][5:0]};
        ok = cp >= MIN_CP3 && !(cp >= SURR_LO && cp <= SURR_HI);
      end else begin
        cp = {w[0][2:0], w[1][5:0], w[2][5:0], w[3][5:0]};
        ok = cp >= MIN_CP4 && cp <= MAX_CP;
      end
      if (ok) begin
        s.cp      = cp;
        s.consume = len;
      end else begin
        s.replaced = 1'b1;
        s.consume  = 3'd1;
      end
    end
    return s;
  endfunction

endpackage

/* rtl/core/u8d_in_if.sv */
// Byte request channel into the UTF-8 decoder.
interface u8d_in_if;
  logic                       valid;
  logic                       ready;
  logic [u8d_pkg::BYTE_W-1:0] text_byte;
  logic                       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

/* rtl/core/u8d_out_if.sv */
// Code point request channel out of the UTF-8 decoder.
interface u8d_out_if;
  logic                     valid;
  logic                     ready;
  logic [u8d_pkg::CP_W-1:0] code_point;
  logic                     replaced;
  logic                     run_last;

  modport source (output valid, output code_point, output replaced, output run_last,
                  input ready);
  modport sink   (input valid, input code_point, input replaced, input run_last,
                  output ready);
endinterface

/* rtl/core/u8d_front.sv */
// Front end: accepts byte requests, tracks the terminator and queues the rest.
module u8d_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  u8d_in_if.sink            in_i,
  input  logic              q_full_i,
  output logic              push_o,
  output u8d_pkg::q_entry_t entry_o
);

  logic after_q, after_d;
  logic accept;
  logic is_zero;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign is_zero    = in_i.text_byte == '0;

  // Bytes after a terminator are dropped here and never reach the back end.
  assign push_o            = accept && !after_q;
  assign entry_o.text_byte = in_i.text_byte;
  assign entry_o.has_byte  = !is_zero;
  assign entry_o.fin       = in_i.end_of_text || is_zero;

  // Terminator tracking: set by a zero byte, cleared by the end of the text.
  always_comb begin
    after_d = after_q;
    if (accept) begin
      if (after_q) begin
        if (in_i.end_of_text) begin
          after_d = 1'b0;
        end
      end else if (is_zero && !in_i.end_of_text) begin
        after_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      after_q <= 1'b0;
    end else begin
      after_q <= after_d;
    end
  end

endmodule

/* rtl/core/u8d_queue.sv */
// Two-entry queue between the front end and the decode engine.
module u8d_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8d_pkg::q_entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output u8d_pkg::q_entry_t entry_o,
  output logic              empty_o
);

  u8d_pkg::q_entry_t               mem_q [u8d_pkg::QUEUE_DEPTH];
  logic [u8d_pkg::QPTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [u8d_pkg::QCNT_W-1:0]      count_q;
  logic                            do_push, do_pop;

  function automatic logic [u8d_pkg::QCNT_W-1:0] QCNT_INC(logic b);
    return {{(u8d_pkg::QCNT_W-1){1'b0}}, b};
  endfunction

  assign full_o  = count_q == u8d_pkg::QCNT_W'(u8d_pkg::QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign entry_o = mem_q[rd_ptr_q];

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCNT_INC(do_push) - QCNT_INC(do_pop);
    end
  end

endmodule

/* rtl/core/u8d_back.sv */
// Decode engine: holds the byte window and releases one code point per cycle while the output is not stalled.
module u8d_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [u8d_pkg::CP_W-1:0] repl_char_i,
  input  u8d_pkg::q_entry_t        entry_i,
  input  logic                     q_empty_i,
  output logic                     q_pop_o,
  u8d_out_if.source                out_o
);

  u8d_pkg::win_t                win_q, win_d, win_nx;
  logic [u8d_pkg::CNT_W-1:0]    cnt_q, cnt_d, cnt_nx;
  logic                         fin_q, fin_d;
  logic                         busy_q, busy_d;
  logic                         out_valid_q, out_valid_d;
  logic [u8d_pkg::CP_W-1:0]     out_cp_q;
  logic                         out_rep_q, out_last_q;
  u8d_pkg::step_t               step_cur, step_nxt;
  logic                         out_free, emit, pop;

  // Examine the oldest byte, then look one step ahead to mark the last result.
  assign step_cur = u8d_pkg::classify(win_q, cnt_q, fin_q);

  always_comb begin
    unique case (step_cur.consume)
      3'd1:    win_nx = {8'h00, win_q[3:1]};
      3'd2:    win_nx = {16'h0000, win_q[3:2]};
      3'd3:    win_nx = {24'h000000, win_q[3]};
      3'd4:    win_nx = '0;
      default: win_nx = win_q;
    endcase
  end

  assign cnt_nx   = cnt_q - step_cur.consume;
  assign step_nxt = u8d_pkg::classify(win_nx, cnt_nx, fin_q);

  assign out_free = !out_valid_q || out_o.ready;
  assign emit     = busy_q && !step_cur.stop && out_free;
  assign pop      = !busy_q && !q_empty_i;
  assign q_pop_o  = pop;

  // Sequencer: load a queued byte, then step through the window.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    win_d  = win_q;
    fin_d  = fin_q;
    if (pop) begin
      busy_d = 1'b1;
      fin_d  = entry_i.fin;
      if (entry_i.has_byte) begin
        win_d[cnt_q[1:0]] = entry_i.text_byte;
        cnt_d             = cnt_q + 3'd1;
      end
    end else if (busy_q && step_cur.stop) begin
      busy_d = 1'b0;
    end else if (emit) begin
      win_d = win_nx;
      cnt_d = cnt_nx;
      if (step_nxt.stop) begin
        busy_d = 1'b0;
      end
    end
  end

  assign out_valid_d = emit || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      cnt_q       <= cnt_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Window and result payload need no reset.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (emit) begin
      out_cp_q   <= step_cur.replaced ? repl_char_i : step_cur.cp;
      out_rep_q  <= step_cur.replaced;
      out_last_q <= step_nxt.stop;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.code_point = out_cp_q;
  assign out_o.replaced   = out_rep_q;
  assign out_o.run_last   = out_last_q;

  // Between requests at most three bytes stay held.
  a_idle_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> cnt_q <= 3'd3)
    else $error("window holds more than three bytes while idle");

  // A final request drains the whole window.
  a_final_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && step_cur.stop && fin_q |-> cnt_q == '0)
    else $error("bytes left held after a flush");

  // The result marked last ends the request.
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && step_nxt.stop |=> !busy_q && out_valid_q && out_last_q)
    else $error("engine still busy after the last result");

  // A result never comes from an empty window.
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> cnt_q != '0 && step_cur.consume != '0)
    else $error("result released from an empty window");

endmodule

/* rtl/core/utf8_decode_with_replacement_unit.sv */
// Top level of the UTF-8 decoder with replacement, with its register port.
// The decode engine releases the results of a byte one at a time, and takes the next byte
// from the queue only once it is idle again; the front queue hides input gaps.
// Reset (asynchronous, active low) empties the queue and window, clears the terminator
// flag and sets the replacement character to the question mark.
module utf8_decode_with_replacement_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [u8d_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [u8d_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [u8d_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  u8d_in_if.sink                         in_i,
  u8d_out_if.source                      out_o
);

  logic [u8d_pkg::CP_W-1:0] repl_q;
  logic                     cfg_hit;
  logic                     push, q_full, q_empty, q_pop;
  u8d_pkg::q_entry_t        push_entry, pop_entry;

  // Register port: one register, selected by bit 2 of the address.
  assign pready  = 1'b1;
  assign cfg_hit = paddr[2] == u8d_pkg::CFG_REPL_IDX;
  assign prdata  = cfg_hit ? {{(u8d_pkg::CFG_DATA_W - u8d_pkg::CP_W){1'b0}}, repl_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repl_q <= u8d_pkg::REPL_RESET;
    end else if (psel && penable && pwrite && pready && cfg_hit) begin
      repl_q <= pwdata[u8d_pkg::CP_W-1:0];
    end
  end

  u8d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  u8d_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .entry_o (pop_entry),
    .empty_o (q_empty)
  );

  u8d_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .repl_char_i (repl_q),
    .entry_i     (pop_entry),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_o       (out_o)
  );

endmodule
